### design/s88_feedback_chain_slave_assert.svh
// Assertion macros for the feedback chain slave checker.
// Included by the checker file; needs clk and rst in the including scope.
`ifndef S88_FEEDBACK_CHAIN_SLAVE_ASSERT_SVH
`define S88_FEEDBACK_CHAIN_SLAVE_ASSERT_SVH

// Property checked outside reset.
`define S88FC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define S88FC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/s88fc_pkg.sv
// Shared types, codes and helper functions of the feedback chain slave.
// Used by the top level, the front end and the output stage; depends on nothing.
`default_nettype none

package s88fc_pkg;

  // Default number of entries in each store.
  localparam int STORE_DEPTH_DEF = 128;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_XCHG  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // Nibble masks.
  localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
  localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;

  // Where the outgoing byte of an item comes from.
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_FB    = 2'd1,
    SRC_CHAIN = 2'd2
  } src_t;

  // Per-item information carried from the front end to the output stage.
  typedef struct packed {
    src_t src;
    logic tx_valid;
    logic accepted;
    logic led;
  } s1_info_t;

  // Feedback byte count: twice the number of four-transmitter groups.
  function automatic logic [7:0] fb_byte_count(input logic [7:0] n);
    logic [6:0] groups;
    groups = 7'((n - 8'd1) >> 2) + 7'd1;
    return (n == 8'd0) ? 8'd0 : {groups, 1'b0};
  endfunction

  // Reduce an index below the store depth. With a depth of at least 64, an
  // index below 256 needs no more than four compare and subtract steps.
  function automatic logic [8:0] wrap_index(input logic [8:0] v, input int unsigned depth);
    logic [8:0] r;
    logic [8:0] d;
    r = v;
    d = 9'(depth);
    for (int i = 0; i < 4; i++) begin
      if (r >= d) begin
        r = r - d;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/s88_feedback_chain_slave.sv
// Feedback chain slave. Takes one item per clock cycle while the receiver
// keeps out_ready high. An item taken is read from the stores into the read
// stage and moves on into the result register as soon as that register is
// free. A stalled result holds in the result register while one further
// item is read, so the input side keeps taking items until both stages are
// full. The feedback store is kept as two nibble RAMs so a radio reply is a
// plain write. After reset a clearing pass writes zero to every store entry,
// one entry per cycle, so in_ready stays low until all STORE_DEPTH entries
// (128 by default) are cleared. The user must write the transmitter count
// through cfg_write and cfg_data only while the block is idle; the block
// itself does not enforce this. Depends on s88fc_pkg, s88fc_front, s88fc_out
// and s88fc_ram.
`default_nettype none

module s88_feedback_chain_slave #(
  parameter int STORE_DEPTH = s88fc_pkg::STORE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] polled_transmitter,
  input  wire logic [7:0] reply_address,
  input  wire logic [7:0] reply_value,
  input  wire logic [7:0] reply_check,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] tx_byte,
  output      logic       tx_valid,
  output      logic       reply_accepted,
  output      logic       led_on
);

  import s88fc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic          fire;
  logic          clearing;
  logic [AW-1:0] fb_raddr;
  logic [AW-1:0] fb_waddr;
  logic          hi_we;
  logic          lo_we;
  logic [3:0]    nib_wdata;
  logic [AW-1:0] ch_raddr;
  logic [AW-1:0] ch_waddr;
  logic          ch_we;
  logic [7:0]    ch_wdata;
  logic [3:0]    hi_rdata;
  logic [3:0]    lo_rdata;
  logic [7:0]    ch_rdata;
  s1_info_t      info;

  // Decode, pointers and clearing pass.
  s88fc_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .kind               (kind),
    .rx_byte            (rx_byte),
    .polled_transmitter (polled_transmitter),
    .reply_address      (reply_address),
    .reply_value        (reply_value),
    .reply_check        (reply_check),
    .clearing           (clearing),
    .fb_raddr           (fb_raddr),
    .fb_waddr           (fb_waddr),
    .hi_we              (hi_we),
    .lo_we              (lo_we),
    .nib_wdata          (nib_wdata),
    .ch_raddr           (ch_raddr),
    .ch_waddr           (ch_waddr),
    .ch_we              (ch_we),
    .ch_wdata           (ch_wdata),
    .info               (info)
  );

  // High nibbles of the feedback store (even transmitters).
  s88fc_ram #(
    .WIDTH (4),
    .DEPTH (STORE_DEPTH)
  ) u_fb_hi (
    .clk   (clk),
    .we    (hi_we),
    .waddr (fb_waddr),
    .wdata (nib_wdata),
    .re    (fire),
    .raddr (fb_raddr),
    .rdata (hi_rdata)
  );

  // Low nibbles of the feedback store (odd transmitters).
  s88fc_ram #(
    .WIDTH (4),
    .DEPTH (STORE_DEPTH)
  ) u_fb_lo (
    .clk   (clk),
    .we    (lo_we),
    .waddr (fb_waddr),
    .wdata (nib_wdata),
    .re    (fire),
    .raddr (fb_raddr),
    .rdata (lo_rdata)
  );

  // Chain delay buffer.
  s88fc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_chain (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (fire),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // Read stage, result register and handshake.
  s88fc_out u_out (
    .clk            (clk),
    .rst            (rst),
    .clearing       (clearing),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .fire           (fire),
    .info           (info),
    .hi_rdata       (hi_rdata),
    .lo_rdata       (lo_rdata),
    .ch_rdata       (ch_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_byte        (tx_byte),
    .tx_valid       (tx_valid),
    .reply_accepted (reply_accepted),
    .led_on         (led_on)
  );

endmodule

`default_nettype wire

### design/s88fc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module s88fc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read-first registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/s88fc_front.sv
// Front end: decodes each accepted item, keeps the chain and feedback
// pointers, the LED flag, the count register and the clearing pass.
// Depends on s88fc_pkg.
`default_nettype none

module s88fc_front #(
  parameter int STORE_DEPTH = s88fc_pkg::STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic                 cfg_write,
  input  wire logic [7:0]           cfg_data,
  input  wire logic [1:0]           kind,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [7:0]           polled_transmitter,
  input  wire logic [7:0]           reply_address,
  input  wire logic [7:0]           reply_value,
  input  wire logic [7:0]           reply_check,
  output      logic                 clearing,
  output      logic [AW-1:0]        fb_raddr,
  output      logic [AW-1:0]        fb_waddr,
  output      logic                 hi_we,
  output      logic                 lo_we,
  output      logic [3:0]           nib_wdata,
  output      logic [AW-1:0]        ch_raddr,
  output      logic [AW-1:0]        ch_waddr,
  output      logic                 ch_we,
  output      logic [7:0]           ch_wdata,
  output      s88fc_pkg::s1_info_t  info
);

  import s88fc_pkg::*;

  localparam logic [AW-1:0] LAST_INDEX = AW'(STORE_DEPTH - 1);

  logic [7:0]    tcount;
  logic [7:0]    fb_ptr;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          led;
  logic          led_next;
  logic [AW-1:0] clr_addr;

  logic       is_load;
  logic       is_xchg;
  logic       is_reply;
  logic       fb_done;
  logic       reply_ok;
  logic [7:0] byte_count;
  s1_info_t   info_next;

  // Item decode and the reply address and check test.
  always_comb begin
    is_load    = (kind == KIND_LOAD);
    is_xchg    = (kind == KIND_XCHG);
    is_reply   = (kind == KIND_REPLY);
    byte_count = fb_byte_count(tcount);
    fb_done    = (fb_ptr == byte_count);
    reply_ok   = is_reply
               && (({1'b0, polled_transmitter} + 9'd1) == {1'b0, reply_address})
               && (reply_check == (reply_address ^ reply_value));
    led_next   = led ^ reply_ok;
  end

  // Store addresses and write commands. The clearing pass owns the write
  // ports of all three stores until every entry holds zero.
  always_comb begin
    fb_raddr  = is_load ? '0 : AW'(wrap_index({1'b0, fb_ptr}, STORE_DEPTH));
    fb_waddr  = clearing ? clr_addr
                         : AW'(wrap_index({2'b00, polled_transmitter[7:1]}, STORE_DEPTH));
    hi_we     = clearing || (fire && reply_ok && !polled_transmitter[0]);
    lo_we     = clearing || (fire && reply_ok && polled_transmitter[0]);
    nib_wdata = clearing ? 4'h0 : 4'(reply_value & LOW_NIBBLE_MASK);
    ch_raddr  = rd_ptr;
    ch_waddr  = clearing ? clr_addr : wr_ptr;
    ch_we     = clearing || (fire && is_xchg);
    ch_wdata  = clearing ? 8'h00 : rx_byte;
  end

  // Information for the output stage.
  always_comb begin
    info_next.src      = SRC_NONE;
    info_next.tx_valid = is_load || is_xchg;
    info_next.accepted = reply_ok;
    info_next.led      = led_next;
    if (is_load || (is_xchg && !fb_done)) begin
      info_next.src = SRC_FB;
    end else if (is_xchg) begin
      info_next.src = SRC_CHAIN;
    end
  end

  // Item information travels alongside the registered store reads.
  always_ff @(posedge clk) begin
    if (fire) begin
      info <= info_next;
    end
  end

  // Clearing pass after reset: one store entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_INDEX) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pointers, LED flag and count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tcount <= 8'd1;
      fb_ptr <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      led    <= 1'b0;
    end else begin
      if (cfg_write) begin
        tcount <= cfg_data;
      end
      if (fire) begin
        led <= led_next;
        if (is_load) begin
          fb_ptr <= 8'd1;
          wr_ptr <= '0;
          rd_ptr <= '0;
        end else if (is_xchg) begin
          if (fb_done) begin
            rd_ptr <= (rd_ptr == LAST_INDEX) ? '0 : rd_ptr + 1'b1;
          end else begin
            fb_ptr <= fb_ptr + 8'd1;
          end
          wr_ptr <= (wr_ptr == LAST_INDEX) ? '0 : wr_ptr + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/s88fc_out.sv
// Output side: stage after the store reads and the result register, with
// the valid and ready handshake of both channels. Depends on s88fc_pkg.
`default_nettype none

module s88fc_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clearing,
  input  wire logic                in_valid,
  output      logic                in_ready,
  output      logic                fire,
  input  wire s88fc_pkg::s1_info_t info,
  input  wire logic [3:0]          hi_rdata,
  input  wire logic [3:0]          lo_rdata,
  input  wire logic [7:0]          ch_rdata,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [7:0]          tx_byte,
  output      logic                tx_valid,
  output      logic                reply_accepted,
  output      logic                led_on
);

  import s88fc_pkg::*;

  logic       s1_valid;
  logic       s1_move;
  logic [7:0] tx_next;

  // Handshake: the read stage advances when the result register is free.
  // No item is taken while the stores are being cleared.
  always_comb begin
    s1_move  = s1_valid && (!out_valid || out_ready);
    in_ready = !clearing && (!s1_valid || s1_move);
    fire     = in_valid && in_ready;
  end

  // Outgoing byte.
  always_comb begin
    unique case (info.src)
      SRC_FB: begin
        tx_next = {hi_rdata, lo_rdata};
      end
      SRC_CHAIN: begin
        tx_next = ch_rdata;
      end
      default: begin
        tx_next = 8'h00;
      end
    endcase
  end

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      tx_byte        <= tx_next;
      tx_valid       <= info.tx_valid;
      reply_accepted <= info.accepted;
      led_on         <= info.led;
    end
  end

endmodule

`default_nettype wire

### design/s88fc_checker.sv
// Port-level checker for the feedback chain slave, bound to the top level.
// Depends on s88_feedback_chain_slave_assert.svh.
`default_nettype none

module s88fc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] tx_byte,
  input wire logic       tx_valid,
  input wire logic       reply_accepted
);

`include "s88_feedback_chain_slave_assert.svh"

  // Reset empties the result register.
  `S88FC_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result pending after reset")

  // Once the input side has opened, it stays open while no result waits.
  `S88FC_ASSERT(a_ready_stays_open, (!out_valid && in_ready) |=> (out_valid || in_ready), "input closed with empty output")

  // A result without a byte carries a zero byte.
  `S88FC_ASSERT(a_zero_byte, (out_valid && !tx_valid) |-> (tx_byte == 8'h00), "nonzero idle byte")

  // A byte result is never a reply acceptance.
  `S88FC_ASSERT(a_tx_not_reply, (out_valid && tx_valid) |-> !reply_accepted, "byte and reply together")

  // A stalled result holds.
  `S88FC_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte)), "stalled result changed")

endmodule

bind s88_feedback_chain_slave s88fc_checker u_checker (.*);

`default_nettype wire
